>>> hdl/tmr_pkg.sv
// tmr_pkg: shared types and constants for the matrix reduction block
// holds the command, queue, result and sequencer types; no dependencies
package tmr_pkg;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [5:0] SIZE_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_RUN,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        in_range;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_type;

   typedef struct packed {
      logic [31:0] cost_bound;
      logic [31:0] penalty;
      logic [4:0]  best_row;
      logic [4:0]  best_col;
      logic [31:0] from_label;
      logic [31:0] to_label;
      logic        found;
      logic [31:0] read_cost;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_ROW_MIN,
      ST_ROW_SUB,
      ST_COL_MIN,
      ST_COL_SUB,
      ST_PEN_MIN,
      ST_PEN_SCAN,
      ST_LABEL_FROM,
      ST_LABEL_TO,
      ST_LABEL_END,
      ST_RESULT
   } eng_state_type;

endpackage

>>> hdl/tmr_front.sv
// tmr_front: accepts request items, classifies them and queues commands
// depends on tmr_pkg
module tmr_front #(
   parameter int MAX_DIM = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [4:0]         req_row_index,
   input  logic [4:0]         req_col_index,
   input  logic [31:0]        req_cost_value,
   output tmr_pkg::cmdq_type  q_head,
   input  logic               q_pop
);

   tmr_pkg::cmd_type q_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   tmr_pkg::cmd_type cmd;
   logic       keep;
   logic       push;

   always_comb begin
      cmd.row      = req_row_index;
      cmd.col      = req_col_index;
      cmd.value    = req_cost_value;
      cmd.in_range = (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);
      cmd.op       = tmr_pkg::OP_WRITE;
      keep         = 1'b1;
      case (req_mode)
         tmr_pkg::MODE_WRITE: cmd.op = tmr_pkg::OP_WRITE;
         tmr_pkg::MODE_RUN:   cmd.op = tmr_pkg::OP_RUN;
         tmr_pkg::MODE_READ:  cmd.op = tmr_pkg::OP_READ;
         default:             keep   = 1'b0;
      endcase
   end

   assign req_stall    = (cnt_ff == 2'd2);
   assign push         = req_valid && !req_stall && keep;
   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.cmd   = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ q_pop;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd;
      end
   end

endmodule

>>> hdl/tmr_engine.sv
// tmr_engine: cost matrix memory and the reduction / penalty sequencer
// depends on tmr_pkg; takes commands from tmr_front
module tmr_engine #(
   parameter int MAX_DIM    = 32,
   parameter int COST_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  tmr_pkg::cmdq_type q_head,
   output logic              q_pop,
   input  logic [5:0]        size_in_use,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmr_pkg::rsp_type  rsp
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int NW    = $clog2(MAX_DIM + 1);
   localparam int AW    = 2 * IDX_W;
   localparam int DEPTH = 1 << AW;
   localparam int ROWS  = 1 << IDX_W;
   localparam logic [COST_WIDTH-1:0] INF = {COST_WIDTH{1'b1}};

   logic [COST_WIDTH-1:0] mem [DEPTH];
   logic [COST_WIDTH-1:0] mem_rd_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [COST_WIDTH-1:0] mem_wd;

   logic [IDX_W-1:0]      cst_idx_mem [ROWS];
   logic [COST_WIDTH-1:0] cst_min2_mem [ROWS];
   logic [IDX_W-1:0]      cst_idx_rd_ff;
   logic [COST_WIDTH-1:0] cst_min2_rd_ff;
   logic                  cst_we;
   logic [IDX_W-1:0]      cst_wa, cst_ra, cst_wd_idx;
   logic [COST_WIDTH-1:0] cst_wd_min2;

   tmr_pkg::eng_state_type state_ff, state_in;
   logic [NW-1:0]         n_ff, n_in, j_ff, j_in, k_ff, k_in;
   logic                  p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]      p_k_ff, p_k_in;
   logic [AW-1:0]         p_addr_ff, p_addr_in;
   logic [COST_WIDTH-1:0] min1_ff, min1_in, min2_ff, min2_in;
   logic [IDX_W-1:0]      midx_ff, midx_in;
   logic [COST_WIDTH-1:0] m_ff, m_in, rmin2_ff, rmin2_in;
   logic [IDX_W-1:0]      ridx_ff, ridx_in;
   logic [COST_WIDTH-1:0] bound_ff, bound_in, best_ff, best_in;
   logic [IDX_W-1:0]      br_ff, br_in, bc_ff, bc_in;
   logic                  found_ff, found_in;
   logic [COST_WIDTH-1:0] from_ff, from_in, to_ff, to_in, rdc_ff, rdc_in;
   tmr_pkg::cmd_type      cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tmr_pkg::rsp_type      rsp_ff, rsp_in;

   logic [NW-1:0]         n_val;
   logic                  done, last;
   logic [COST_WIDTH-1:0] v, pen_a, pen_b, pen_p;
   logic                  fin;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      if (int'(size_in_use) > MAX_DIM) begin
         n_val = NW'(MAX_DIM);
      end else begin
         n_val = NW'(size_in_use);
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      p_valid_in   = 1'b0;
      p_k_in       = p_k_ff;
      p_addr_in    = p_addr_ff;
      min1_in      = min1_ff;
      min2_in      = min2_ff;
      midx_in      = midx_ff;
      m_in         = m_ff;
      rmin2_in     = rmin2_ff;
      ridx_in      = ridx_ff;
      bound_in     = bound_ff;
      best_in      = best_ff;
      br_in        = br_ff;
      bc_in        = bc_ff;
      found_in     = found_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      rdc_in       = rdc_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = p_addr_ff;
      mem_wd       = '0;
      mem_ra       = '0;
      cst_we       = 1'b0;
      cst_wa       = j_ff[IDX_W-1:0];
      cst_wd_idx   = midx_ff;
      cst_wd_min2  = INF;
      cst_ra       = k_ff[IDX_W-1:0];
      v            = mem_rd_ff;
      fin          = (v != INF);
      pen_a        = '0;
      pen_b        = '0;
      pen_p        = '0;
      done         = (k_ff == n_ff) && !p_valid_ff;
      last         = (NW'(j_ff + NW'(1)) == n_ff);

      // issue side of a sweep: one matrix read per cycle
      if (state_ff inside {tmr_pkg::ST_ROW_MIN, tmr_pkg::ST_ROW_SUB, tmr_pkg::ST_COL_MIN,
                           tmr_pkg::ST_COL_SUB, tmr_pkg::ST_PEN_MIN, tmr_pkg::ST_PEN_SCAN}) begin
         if (state_ff == tmr_pkg::ST_COL_MIN || state_ff == tmr_pkg::ST_COL_SUB) begin
            mem_ra = {k_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
         end else begin
            mem_ra = {j_ff[IDX_W-1:0], k_ff[IDX_W-1:0]};
         end
         if (k_ff < n_ff) begin
            p_valid_in = 1'b1;
            p_k_in     = k_ff[IDX_W-1:0];
            p_addr_in  = mem_ra;
            k_in       = k_ff + NW'(1);
         end
      end

      // data side of a sweep, in the cycle after the read is issued
      if (p_valid_ff) begin
         case (state_ff)
            tmr_pkg::ST_ROW_MIN, tmr_pkg::ST_COL_MIN, tmr_pkg::ST_PEN_MIN: begin
               if (fin && v < min1_ff) begin
                  min2_in = min1_ff;
                  min1_in = v;
                  midx_in = p_k_ff;
               end else if (fin && v < min2_ff) begin
                  min2_in = v;
               end
            end
            tmr_pkg::ST_ROW_SUB, tmr_pkg::ST_COL_SUB: begin
               mem_we = fin;
               mem_wd = v - m_ff;
            end
            tmr_pkg::ST_PEN_SCAN: begin
               if (v == '0) begin
                  pen_a = (p_k_ff == ridx_ff) ? rmin2_ff : '0;
                  pen_b = (j_ff[IDX_W-1:0] == cst_idx_rd_ff) ? cst_min2_rd_ff : '0;
                  pen_p = (pen_a > INF - pen_b) ? INF : pen_a + pen_b;
                  if (pen_p > best_ff) begin
                     best_in  = pen_p;
                     br_in    = j_ff[IDX_W-1:0];
                     bc_in    = p_k_ff;
                     found_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         tmr_pkg::ST_IDLE: begin
            mem_ra = {IDX_W'(q_head.cmd.row), IDX_W'(q_head.cmd.col)};
            if (q_head.valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head.cmd;
               bound_in = '0;
               best_in  = '0;
               br_in    = '0;
               bc_in    = '0;
               found_in = 1'b0;
               from_in  = '0;
               to_in    = '0;
               rdc_in   = '0;
               min1_in  = INF;
               min2_in  = INF;
               midx_in  = '0;
               j_in     = NW'(1);
               k_in     = NW'(1);
               n_in     = n_val;
               case (q_head.cmd.op)
                  tmr_pkg::OP_WRITE: begin
                     mem_we = q_head.cmd.in_range;
                     mem_wa = mem_ra;
                     mem_wd = COST_WIDTH'(q_head.cmd.value);
                  end
                  tmr_pkg::OP_READ: state_in = tmr_pkg::ST_READ_WAIT;
                  tmr_pkg::OP_RUN: begin
                     if (n_val < NW'(2)) begin
                        state_in = tmr_pkg::ST_RESULT;
                     end else begin
                        state_in = tmr_pkg::ST_ROW_MIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tmr_pkg::ST_READ_WAIT: begin
            rdc_in   = cmd_ff.in_range ? mem_rd_ff : '0;
            state_in = tmr_pkg::ST_RESULT;
         end
         tmr_pkg::ST_ROW_MIN: begin
            if (done) begin
               m_in     = min1_ff;
               bound_in = bound_ff + min1_ff;
               min1_in  = INF;
               min2_in  = INF;
               midx_in  = '0;
               k_in     = NW'(1);
               state_in = tmr_pkg::ST_ROW_SUB;
            end
         end
         tmr_pkg::ST_ROW_SUB: begin
            if (done) begin
               k_in = NW'(1);
               if (last) begin
                  j_in     = NW'(1);
                  state_in = tmr_pkg::ST_COL_MIN;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = tmr_pkg::ST_ROW_MIN;
               end
            end
         end
         tmr_pkg::ST_COL_MIN: begin
            if (done) begin
               m_in        = min1_ff;
               bound_in    = bound_ff + min1_ff;
               // column stats as they stand after this column is reduced
               cst_we      = 1'b1;
               cst_wd_min2 = (min2_ff == INF) ? INF : min2_ff - min1_ff;
               min1_in     = INF;
               min2_in     = INF;
               midx_in     = '0;
               k_in        = NW'(1);
               state_in    = tmr_pkg::ST_COL_SUB;
            end
         end
         tmr_pkg::ST_COL_SUB: begin
            if (done) begin
               k_in = NW'(1);
               if (last) begin
                  j_in     = NW'(1);
                  state_in = tmr_pkg::ST_PEN_MIN;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = tmr_pkg::ST_COL_MIN;
               end
            end
         end
         tmr_pkg::ST_PEN_MIN: begin
            if (done) begin
               ridx_in  = midx_ff;
               rmin2_in = min2_ff;
               min1_in  = INF;
               min2_in  = INF;
               midx_in  = '0;
               k_in     = NW'(1);
               state_in = tmr_pkg::ST_PEN_SCAN;
            end
         end
         tmr_pkg::ST_PEN_SCAN: begin
            if (done) begin
               k_in = NW'(1);
               if (last) begin
                  state_in = found_ff ? tmr_pkg::ST_LABEL_FROM : tmr_pkg::ST_RESULT;
               end else begin
                  j_in     = j_ff + NW'(1);
                  state_in = tmr_pkg::ST_PEN_MIN;
               end
            end
         end
         tmr_pkg::ST_LABEL_FROM: begin
            mem_ra   = {br_ff, {IDX_W{1'b0}}};
            state_in = tmr_pkg::ST_LABEL_TO;
         end
         tmr_pkg::ST_LABEL_TO: begin
            from_in  = mem_rd_ff;
            mem_ra   = {bc_ff, {IDX_W{1'b0}}};
            state_in = tmr_pkg::ST_LABEL_END;
         end
         tmr_pkg::ST_LABEL_END: begin
            to_in    = mem_rd_ff;
            state_in = tmr_pkg::ST_RESULT;
         end
         tmr_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.cost_bound  = 32'(bound_ff);
               rsp_in.penalty     = 32'(best_ff);
               rsp_in.best_row    = 5'(br_ff);
               rsp_in.best_col    = 5'(bc_ff);
               rsp_in.from_label  = 32'(from_ff);
               rsp_in.to_label    = 32'(to_ff);
               rsp_in.found       = found_ff;
               rsp_in.read_cost   = 32'(rdc_ff);
               state_in           = tmr_pkg::ST_IDLE;
            end
         end
         default: state_in = tmr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmr_pkg::ST_IDLE;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      p_k_ff    <= p_k_in;
      p_addr_ff <= p_addr_in;
      min1_ff   <= min1_in;
      min2_ff   <= min2_in;
      midx_ff   <= midx_in;
      m_ff      <= m_in;
      rmin2_ff  <= rmin2_in;
      ridx_ff   <= ridx_in;
      bound_ff  <= bound_in;
      best_ff   <= best_in;
      br_ff     <= br_in;
      bc_ff     <= bc_in;
      found_ff  <= found_in;
      from_ff   <= from_in;
      to_ff     <= to_in;
      rdc_ff    <= rdc_in;
      cmd_ff    <= cmd_in;
      rsp_ff    <= rsp_in;
   end

   // cost matrix: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // per column: row of first minimum and second minimum after reduction
   always_ff @(posedge clock) begin
      if (cst_we) begin
         cst_idx_mem[cst_wa]  <= cst_wd_idx;
         cst_min2_mem[cst_wa] <= cst_wd_min2;
      end
      cst_idx_rd_ff  <= cst_idx_mem[cst_ra];
      cst_min2_rd_ff <= cst_min2_mem[cst_ra];
   end

endmodule

>>> hdl/tsp_matrix_reduce_penalty.sv
// tsp_matrix_reduce_penalty: top level of the cost matrix reduction block, needs tmr_pkg
// reads and runs answer on rsp_valid, writes give no result; n = min(size_in_use, MAX_DIM);
// a run with n < 2 goes straight to the result, one with no edge found skips the label reads
// one item is worked at a time, the front queue holds two more; writes go one a cycle while the engine is idle
// reset: synchronous active-high, clears control and sets size_in_use to 32;
// matrix contents are undefined until written
module tsp_matrix_reduce_penalty #(
   parameter int MAX_DIM    = 32,
   parameter int COST_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_row_index,
   input  logic [4:0]  req_col_index,
   input  logic [31:0] req_cost_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cost_bound,
   output logic [31:0] rsp_penalty,
   output logic [4:0]  rsp_best_row,
   output logic [4:0]  rsp_best_col,
   output logic [31:0] rsp_from_label,
   output logic [31:0] rsp_to_label,
   output logic        rsp_found,
   output logic [31:0] rsp_read_cost,
   // size register
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   logic [5:0]        size_ff, size_in;
   tmr_pkg::cmdq_type q_head;
   logic              q_pop;
   tmr_pkg::rsp_type  rsp;

   // matrix dimension in use, label row and column included
   always_comb begin
      size_in = csr_wr_en ? csr_wr_data : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= tmr_pkg::SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // front: takes items, drops unused mode codes, queues commands
   tmr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_cost_value (req_cost_value),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   // back: matrix memory, row/column reduction, penalty scan, result register
   tmr_engine #(
      .MAX_DIM    (MAX_DIM),
      .COST_WIDTH (COST_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .size_in_use (size_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_cost_bound  = rsp.cost_bound;
   assign rsp_penalty     = rsp.penalty;
   assign rsp_best_row    = rsp.best_row;
   assign rsp_best_col    = rsp.best_col;
   assign rsp_from_label  = rsp.from_label;
   assign rsp_to_label    = rsp.to_label;
   assign rsp_found       = rsp.found;
   assign rsp_read_cost   = rsp.read_cost;

endmodule

>>> hdl/tmr_checker.sv
// tmr_checker: port-level assertions for tsp_matrix_reduce_penalty
// bound to the top level below; no package dependency
module tmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_cost_bound,
   input logic [31:0] rsp_penalty,
   input logic [4:0]  rsp_best_row,
   input logic [4:0]  rsp_best_col,
   input logic        rsp_found,
   input logic [31:0] rsp_read_cost
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cost_bound)
         && $stable(rsp_penalty) && $stable(rsp_read_cost))
      else $error("stalled result changed");

   // nothing found means an empty edge
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_penalty == 32'd0 && rsp_best_row == 5'd0
         && rsp_best_col == 5'd0)
      else $error("edge fields set without a found edge");

   // a found edge sits off the label row and column with a positive penalty
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_penalty != 32'd0 && rsp_best_row != 5'd0
         && rsp_best_col != 5'd0 && rsp_read_cost == 32'd0)
      else $error("found edge malformed");

   // read data only comes with an otherwise empty result
   a_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_cost != 32'd0 |-> rsp_cost_bound == 32'd0 && !rsp_found)
      else $error("read result mixed with run fields");

endmodule

bind tsp_matrix_reduce_penalty tmr_checker u_tmr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_cost_bound  (rsp_cost_bound),
   .rsp_penalty     (rsp_penalty),
   .rsp_best_row    (rsp_best_row),
   .rsp_best_col    (rsp_best_col),
   .rsp_found       (rsp_found),
   .rsp_read_cost   (rsp_read_cost)
);
